### sv/decimal_to_float_converter_assert.svh
// Assertion macros used by the converter RTL
`ifndef DECIMAL_TO_FLOAT_CONVERTER_ASSERT_SVH
`define DECIMAL_TO_FLOAT_CONVERTER_ASSERT_SVH

// Clocked assertion, disabled while in reset
`define D2F_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define D2F_ASSERT_IMP(label, ante, cons, msg) \
  `D2F_ASSERT(label, (ante) |-> (cons), msg)

`endif

### sv/d2f_pkg.sv
package d2f_pkg;

  localparam int MANT_W_DEF = 96;
  localparam int LOW_W      = 64;
  localparam int HIGH_W     = 32;
  localparam int SCALE_W    = 5;
  localparam int FLOAT_W    = 32;
  localparam int NORM_W     = 128;
  localparam int Q_BITS     = 26;
  localparam int N_SCALE    = 32;
  localparam int EXP_W      = 9;
  localparam int DEXP_W     = 7;
  localparam int FRAC_W     = 23;
  localparam int BIAS_M1    = 126;

  typedef logic [NORM_W-1:0] norm_t;
  typedef norm_t             dtab_t [N_SCALE];
  typedef logic [DEXP_W-1:0] dexp_t [N_SCALE];

  // 10^s shifted so its top bit sits at NORM_W-1
  function automatic dtab_t build_dtab();
    norm_t p;
    norm_t n;
    dtab_t t;
    p = norm_t'(1);
    for (int s = 0; s < N_SCALE; s++) begin
      n = p;
      for (int k = 0; k < NORM_W; k++) begin
        if (!n[NORM_W-1]) n = n << 1;
      end
      t[s] = n;
      p = (p << 3) + (p << 1);
    end
    return t;
  endfunction

  // bit position of the top bit of 10^s
  function automatic dexp_t build_dexp();
    norm_t p;
    dexp_t t;
    p = norm_t'(1);
    for (int s = 0; s < N_SCALE; s++) begin
      t[s] = '0;
      for (int k = 0; k < NORM_W; k++) begin
        if (p[k]) t[s] = DEXP_W'(k);
      end
      p = (p << 3) + (p << 1);
    end
    return t;
  endfunction

  localparam dtab_t DN_TAB = build_dtab();
  localparam dexp_t DE_TAB = build_dexp();

  typedef struct packed {
    logic               valid;
    logic               sign;
    logic               zero;
    logic [EXP_W-1:0]   expo;
    logic [SCALE_W-1:0] scale;
    logic [NORM_W:0]    rem;
    logic [Q_BITS-1:0]  quo;
  } div_t;

endpackage

### sv/d2f_if.sv
interface d2f_in_if;
  logic                        valid;
  logic                        ready;
  logic [d2f_pkg::LOW_W-1:0]   mantissa_low;
  logic [d2f_pkg::HIGH_W-1:0]  mantissa_high;
  logic [d2f_pkg::SCALE_W-1:0] decimal_scale;
  logic                        negative;

  modport source (output valid, mantissa_low, mantissa_high, decimal_scale, negative,
                  input ready);
  modport sink   (input valid, mantissa_low, mantissa_high, decimal_scale, negative,
                  output ready);
endinterface

interface d2f_out_if;
  logic                        valid;
  logic                        ready;
  logic [d2f_pkg::FLOAT_W-1:0] float_bits;

  modport source (output valid, float_bits, input ready);
  modport sink   (input valid, float_bits, output ready);
endinterface

### sv/d2f_div_stage.sv
module d2f_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  d2f_pkg::div_t d_in,
  output d2f_pkg::div_t d_out
);
  import d2f_pkg::*;

  logic [NORM_W:0] dvs;
  logic [NORM_W:0] diff;
  logic            ge;
  div_t            d_nxt;
  div_t            d_r;

  always_comb begin
    dvs   = {1'b0, DN_TAB[d_in.scale]};
    ge    = d_in.rem >= dvs;
    diff  = ge ? (d_in.rem - dvs) : d_in.rem;
    d_nxt = d_in;
    d_nxt.rem = {diff[NORM_W-1:0], 1'b0};
    d_nxt.quo = {d_in.quo[Q_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

### sv/decimal_to_float_converter.sv
// Channel | Dir | Payload
// in_ch   | in  | mantissa_low[63:0], mantissa_high[31:0], decimal_scale[4:0], negative
// out_ch  | out | float_bits[31:0]
// One request per cycle while out_ch is not stalled; stages: input, leading-one, normalize,
// 26 restoring-division steps of 129 bits, round/output.
// The 26 division stages set the depth, one quotient bit per stage.
// Synchronous active-low reset clears all valid bits.
// A stall on out_ch freezes the whole pipeline; in_ch.ready follows it.
module decimal_to_float_converter #(
  parameter int MANTISSA_WIDTH = d2f_pkg::MANT_W_DEF
) (
  input logic       clk,
  input logic       rst_n,
  d2f_in_if.sink    in_ch,
  d2f_out_if.source out_ch
);
  import d2f_pkg::*;
  `include "decimal_to_float_converter_assert.svh"

  localparam int LZ_W = $clog2(MANTISSA_WIDTH);

  logic adv;

  logic                      v0_r, sign0_r;
  logic [SCALE_W-1:0]        scale0_r;
  logic [MANTISSA_WIDTH-1:0] m0_r;

  logic                      v1_r, sign1_r, zero1_r;
  logic [SCALE_W-1:0]        scale1_r;
  logic [MANTISSA_WIDTH-1:0] m1_r;
  logic [LZ_W-1:0]           msb1_r;
  logic [LZ_W-1:0]           msb_nxt;
  logic                      zero_nxt;

  norm_t norm_wide;
  norm_t mn;
  logic [LZ_W-1:0] lz;
  div_t  d2_nxt;
  div_t  chain0_r;
  div_t  chain [Q_BITS+1];

  div_t                 fin;
  logic                 top;
  logic [FRAC_W:0]      mfrac;
  logic                 rb, st, inc;
  logic [EXP_W-1:0]     ef;
  logic [FLOAT_W-1:0]   sum;
  logic [FLOAT_W-1:0]   res;
  logic                 out_valid_r;
  logic [FLOAT_W-1:0]   out_bits_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
      v1_r <= v0_r;
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_r     <= MANTISSA_WIDTH'({in_ch.mantissa_high, in_ch.mantissa_low});
      scale0_r <= in_ch.decimal_scale;
      sign0_r  <= in_ch.negative;
      m1_r     <= m0_r;
      scale1_r <= scale0_r;
      sign1_r  <= sign0_r;
      msb1_r   <= msb_nxt;
      zero1_r  <= zero_nxt;
      out_bits_r <= res;
    end
  end

  // leading one of the mantissa
  always_comb begin
    msb_nxt  = '0;
    zero_nxt = 1'b1;
    for (int i = 0; i < MANTISSA_WIDTH; i++) begin
      if (m0_r[i]) begin
        msb_nxt  = LZ_W'(i);
        zero_nxt = 1'b0;
      end
    end
  end

  // normalize so the top bit lands at NORM_W-1
  always_comb begin
    lz        = LZ_W'(MANTISSA_WIDTH - 1) - msb1_r;
    norm_wide = {m1_r, {(NORM_W-MANTISSA_WIDTH){1'b0}}};
    mn        = norm_wide << lz;
    d2_nxt.valid = v1_r;
    d2_nxt.sign  = sign1_r;
    d2_nxt.zero  = zero1_r;
    d2_nxt.scale = scale1_r;
    d2_nxt.expo  = EXP_W'(msb1_r) - EXP_W'(DE_TAB[scale1_r]) + EXP_W'(BIAS_M1);
    d2_nxt.rem   = {1'b0, mn};
    d2_nxt.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain0_r.valid <= 1'b0;
    end else if (adv) begin
      chain0_r <= d2_nxt;
    end
  end

  assign chain[0] = chain0_r;

  for (genvar g = 0; g < Q_BITS; g++) begin : g_div
    d2f_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  // round to nearest, ties to even
  always_comb begin
    fin   = chain[Q_BITS];
    top   = fin.quo[Q_BITS-1];
    mfrac = top ? fin.quo[Q_BITS-1:2] : fin.quo[Q_BITS-2:1];
    rb    = top ? fin.quo[1] : fin.quo[0];
    st    = (top && fin.quo[0]) || (fin.rem != '0);
    inc   = rb && (st || mfrac[0]);
    ef    = top ? fin.expo : (fin.expo - EXP_W'(1));
    sum   = {1'b0, ef[7:0], {FRAC_W{1'b0}}} + FLOAT_W'(mfrac) + FLOAT_W'(inc);
    res   = fin.zero ? {fin.sign, {(FLOAT_W-1){1'b0}}} : {fin.sign, sum[FLOAT_W-2:0]};
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.float_bits = out_bits_r;

  `D2F_ASSERT_IMP(a_norm_top, chain[0].valid && !chain[0].zero, chain[0].rem[NORM_W-1], "normalize lost top bit")
  `D2F_ASSERT_IMP(a_quo_lead, fin.valid && !fin.zero, fin.quo[Q_BITS-1] || fin.quo[Q_BITS-2], "quotient not normalized")
  `D2F_ASSERT_IMP(a_rem_bound, fin.valid, fin.rem < {DN_TAB[fin.scale], 1'b0}, "remainder out of range")
  `D2F_ASSERT_IMP(a_exp_range, out_ch.valid && (out_ch.float_bits[30:0] != '0), (out_ch.float_bits[30:23] != 8'h00) && (out_ch.float_bits[30:23] != 8'hff), "exponent not normal")

endmodule

### dv/tb_top.sv
module tb_top;
  import d2f_pkg::*;

  class float_scoreboard;
    bit [31:0] pending_bits[$];
    int        errors;

    function bit [31:0] convert(bit [63:0] lo, bit [31:0] hi, bit [4:0] sc, bit neg);
      bit [223:0] num;
      bit [223:0] div;
      bit [223:0] quo;
      bit [223:0] rem;
      bit [223:0] low_mask;
      bit [23:0]  frac;
      bit         guard;
      bit         sticky;
      int         msb;
      num = {32'd0, hi, lo, 128'd0};
      div = 224'd1;
      for (int k = 0; k < sc; k++) div = div * 10;
      quo = num / div;
      rem = num % div;
      msb = -1;
      for (int i = 223; i >= 0; i--) begin
        if (quo[i] && msb < 0) msb = i;
      end
      if (msb < 0) return {neg, 31'd0};
      frac = 24'(quo >> (msb - 23));
      guard = quo[msb-24];
      low_mask = (224'd1 << (msb - 24)) - 1;
      sticky = (rem != 0) || ((quo & low_mask) != 0);
      return {neg, 31'd0} + (32'(msb - 2) << 23) + 32'(frac) + 32'(guard && (sticky || frac[0]));
    endfunction

    function void note_request(bit [63:0] lo, bit [31:0] hi, bit [4:0] sc, bit neg);
      pending_bits.push_back(convert(lo, hi, sc, neg));
    endfunction

    function void check_result(bit [31:0] got);
      bit [31:0] want;
      if (pending_bits.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_bits.pop_front();
      if (want !== got) begin
        $display("%0t: float_bits expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  bit   sink_active = 1'b0;

  d2f_in_if  in_ch();
  d2f_out_if out_ch();

  decimal_to_float_converter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  float_scoreboard sb = new();

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 500000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result side: random backpressure while sink_active, checked on the falling edge
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!sink_active) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall = gap_len();
        if (stall == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (stall - 1) @(posedge clk);
          @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.float_bits);
  end

  task automatic send_request(bit [63:0] lo, bit [31:0] hi, bit [4:0] sc, bit neg);
    int idle;
    idle = gap_len();
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mantissa_low  <= lo;
    in_ch.mantissa_high <= hi;
    in_ch.decimal_scale <= sc;
    in_ch.negative      <= neg;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    sb.note_request(lo, hi, sc, neg);
    @(posedge clk);
  endtask

  task automatic send_random();
    bit [95:0] m;
    bit [4:0]  sc;
    int        width;
    m = {$urandom, $urandom, $urandom};
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        width = $urandom_range(1, 96);
        m = m & ((96'd1 << width) - 1);
      end
      2: m = 96'($urandom_range(0, 1000));
      default: m = m | ~((96'd1 << $urandom_range(0, 95)) - 1);
    endcase
    sc = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(29, 31)) : 5'($urandom_range(0, 28));
    send_request(m[63:0], m[95:64], sc, 1'($urandom));
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.mantissa_low  = '0;
    in_ch.mantissa_high = '0;
    in_ch.decimal_scale = '0;
    in_ch.negative      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zeros, extremes, ties
    send_request(64'd0, 32'd0, 5'd0, 1'b0);
    send_request(64'd0, 32'd0, 5'd17, 1'b1);
    send_request('1, '1, 5'd0, 1'b0);
    send_request('1, '1, 5'd28, 1'b1);
    send_request('1, '1, 5'd31, 1'b0);
    send_request(64'd1, 32'd0, 5'd28, 1'b0);
    send_request(64'd1, 32'd0, 5'd31, 1'b1);
    send_request(64'd1, 32'd0, 5'd0, 1'b0);
    send_request(64'd16777217, 32'd0, 5'd0, 1'b0);
    send_request(64'd16777219, 32'd0, 5'd0, 1'b1);
    send_request(64'd33554435, 32'd0, 5'd0, 1'b0);
    send_request(64'd15, 32'd0, 5'd1, 1'b0);
    send_request(64'd0, 32'h8000_0000, 5'd0, 1'b0);
    send_request(64'h8000_0000_0000_0000, 32'd0, 5'd10, 1'b1);
    send_request(64'd123456789, 32'd0, 5'd9, 1'b0);
    send_request('1, 32'd0, 5'd19, 1'b0);
    send_request(64'd1, 32'd0, 5'd1, 1'b0);
    send_request(64'd3, 32'd0, 5'd1, 1'b1);

    sink_active = 1'b1;
    for (int n = 0; n < 1300; n++) begin
      if (n % 200 < 20) sink_active = 1'b0;
      else sink_active = 1'b1;
      send_random();
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_bits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+sv
sv/d2f_pkg.sv
sv/d2f_if.sv
sv/d2f_div_stage.sv
sv/decimal_to_float_converter.sv
dv/tb_top.sv
